// File: rtl/core/fcms_pkg.sv
// Shared constants and types for the flow count-min sketch.
`default_nettype none

package fcms_pkg;

    localparam int ROWS    = 4;
    localparam int COLUMNS = 1024;   // power of two: the column is the low hash bits

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int CNT_W  = $clog2(ROWS + 1);

    localparam int CTR_W          = 32;
    localparam int HASH_SHIFT     = 5;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int KEY_PREFIX_LEN = 13;   // bytes shared by all rows
    localparam int KEY_IDX_W      = $clog2(KEY_PREFIX_LEN);

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_BUMP,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/flow_count_min_sketch.sv
// Count-min sketch over flow 5-tuples: hash, counter update and counter read.
// Count word: byte hashing of the key prefix, then a read-increment-write of each row's
//   counter in the counter RAM; the result is the minimum of the incremented counters.
// Read word or uncounted protocol: result 1 cycle after acceptance, next word 1 cycle later.
// The next word is taken while a result waits downstream; a second result holds the input.
// After reset a clearing pass zeroes all 4096 RAM counters, one counter a cycle;
// no word is taken until it ends.
`default_nettype none

module flow_count_min_sketch (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // src_addr, dst_addr, sport, dport, protocol, read_row, read_column, zero pad
    input  wire logic [fcms_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  wire logic                           s_axis_tuser,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // value
    output      logic [fcms_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // counted
    output      logic                           m_axis_tuser
);

    localparam int ROW_W  = fcms_pkg::ROW_W;
    localparam int COL_W  = fcms_pkg::COL_W;
    localparam int ADDR_W = fcms_pkg::ADDR_W;
    localparam int CNT_W  = fcms_pkg::CNT_W;
    localparam int CTR_W  = fcms_pkg::CTR_W;
    localparam int KLEN   = fcms_pkg::KEY_PREFIX_LEN;
    localparam int KIDX_W = fcms_pkg::KEY_IDX_W;

    // input fields
    logic [31:0] in_src_addr;
    logic [31:0] in_dst_addr;
    logic [15:0] in_sport;
    logic [15:0] in_dport;
    logic [7:0]  in_protocol;
    logic [1:0]  in_read_row;
    logic [9:0]  in_read_column;

    assign in_src_addr    = s_axis_tdata[31:0];
    assign in_dst_addr    = s_axis_tdata[63:32];
    assign in_sport       = s_axis_tdata[79:64];
    assign in_dport       = s_axis_tdata[95:80];
    assign in_protocol    = s_axis_tdata[103:96];
    assign in_read_row    = s_axis_tdata[105:104];
    assign in_read_column = s_axis_tdata[115:106];

    fcms_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [KIDX_W-1:0]      byte_idx_reg, byte_idx_next;
    logic [CNT_W-1:0]       row_reg, row_next;
    logic [31:0]            hash_reg, hash_next;
    logic [CTR_W-1:0]       min_reg, min_next;
    logic [KLEN-1:0][7:0]   key_reg, key_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]      waddr_reg, waddr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CTR_W-1:0]       m_value_reg, m_value_next;
    logic                   m_counted_reg, m_counted_next;

    // counter RAM
    logic [CTR_W-1:0]  mem [fcms_pkg::DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CTR_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CTR_W-1:0]  rdata_reg;

    logic              out_free;
    logic [7:0]        cur_byte;
    logic [CTR_W-1:0]  bumped;
    logic [CTR_W-1:0]  bumped_min;
    logic [COL_W-1:0]  row_col;
    logic              last_row;

    function automatic logic [31:0] djb2_step(input logic [31:0] h, input logic [7:0] b);
        return (h << fcms_pkg::HASH_SHIFT) + h + {{24{b[7]}}, b};
    endfunction

    // finish the hash with the row byte and the trailing zero byte
    function automatic logic [COL_W-1:0] column_of(input logic [31:0] prefix,
                                                   input logic [CNT_W-1:0] row);
        logic [31:0] h;
        h = djb2_step(prefix, 8'(row));
        h = djb2_step(h, 8'd0);
        return h[COL_W-1:0];
    endfunction

    assign out_free   = !m_valid_reg || m_axis_tready;
    assign cur_byte   = key_reg[KIDX_W'(KLEN - 1) - byte_idx_reg];
    assign bumped     = rdata_reg + CTR_W'(1);
    assign bumped_min = (bumped < min_reg) ? bumped : min_reg;
    assign row_col    = column_of(hash_reg, row_reg);
    assign last_row   = (row_reg == CNT_W'(fcms_pkg::ROWS));

    assign s_axis_tready = (state_reg == fcms_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = m_counted_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        byte_idx_next  = byte_idx_reg;
        row_next       = row_reg;
        hash_next      = hash_reg;
        min_next       = min_reg;
        key_next       = key_reg;
        rd_ok_next     = rd_ok_reg;
        waddr_next     = waddr_reg;
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_counted_next = m_counted_reg;
        mem_we         = 1'b0;
        mem_waddr      = waddr_reg;
        mem_wdata      = bumped;
        mem_re         = 1'b0;
        mem_raddr      = {row_reg[ROW_W-1:0], row_col};

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fcms_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == ADDR_W'(fcms_pkg::DEPTH - 1))
                begin
                    state_next = fcms_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            fcms_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next      = {in_src_addr, in_dst_addr, in_sport,
                                     in_dport, in_protocol};
                    hash_next     = fcms_pkg::HASH_SEED;
                    byte_idx_next = '0;
                    row_next      = '0;
                    min_next      = '1;
                    priority if (s_axis_tuser == fcms_pkg::CMD_READ)
                    begin
                        // issue the counter read right away
                        mem_re     = 1'b1;
                        mem_raddr  = {ROW_W'(in_read_row), COL_W'(in_read_column)};
                        rd_ok_next = (32'(in_read_row) < 32'(fcms_pkg::ROWS)) &&
                                     (32'(in_read_column) < 32'(fcms_pkg::COLUMNS));
                        state_next = fcms_pkg::ST_READ;
                    end
                    else if (in_protocol == fcms_pkg::PROTO_TCP ||
                             in_protocol == fcms_pkg::PROTO_UDP)
                    begin
                        state_next = fcms_pkg::ST_HASH;
                    end
                    else
                    begin
                        state_next = fcms_pkg::ST_DONE;
                    end
                end
            end

            fcms_pkg::ST_HASH:
            begin
                hash_next     = djb2_step(hash_reg, cur_byte);
                byte_idx_next = byte_idx_reg + KIDX_W'(1);
                if (byte_idx_reg == KIDX_W'(KLEN - 1))
                begin
                    state_next = fcms_pkg::ST_BUMP;
                end
            end

            fcms_pkg::ST_BUMP:
            begin
                // read row k while writing back row k-1; hold on the last row
                // until the output register is free
                if (!last_row || out_free)
                begin
                    if (row_reg != '0)
                    begin
                        mem_we   = 1'b1;
                        min_next = bumped_min;
                    end
                    if (!last_row)
                    begin
                        mem_re     = 1'b1;
                        waddr_next = {row_reg[ROW_W-1:0], row_col};
                        row_next   = row_reg + CNT_W'(1);
                    end
                    else
                    begin
                        m_valid_next   = 1'b1;
                        m_value_next   = bumped_min;
                        m_counted_next = 1'b1;
                        state_next     = fcms_pkg::ST_IDLE;
                    end
                end
            end

            fcms_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_value_next   = rd_ok_reg ? rdata_reg : '0;
                    m_counted_next = 1'b0;
                    state_next     = fcms_pkg::ST_IDLE;
                end
            end

            fcms_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_value_next   = '0;
                    m_counted_next = 1'b0;
                    state_next     = fcms_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fcms_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            byte_idx_reg <= '0;
            row_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            byte_idx_reg <= byte_idx_next;
            row_reg      <= row_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg      <= hash_next;
        min_reg       <= min_next;
        key_reg       <= key_next;
        rd_ok_reg     <= rd_ok_next;
        waddr_reg     <= waddr_next;
        m_value_reg   <= m_value_next;
        m_counted_reg <= m_counted_next;
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
